>>> hdl/fib_pkg.sv
package fib_pkg;

    localparam int SIZE_WIDTH     = 32;
    localparam int CHROM_WIDTH    = 16;
    localparam int BIN_NUM_WIDTH  = 6;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 32;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_BIN_WIDTH     = 2'd0,
        CFG_RELATIVE_MODE = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SETUP,
        ST_EMIT
    } state_t;

endpackage

>>> hdl/fib_in_if.sv
interface fib_in_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                           valid;
    logic                           ready;
    logic [fib_pkg::CHROM_WIDTH-1:0] chrom_id;
    logic [COORD_WIDTH-1:0]         start_pos;
    logic [COORD_WIDTH-1:0]         end_pos;

    modport source (output valid, output chrom_id, output start_pos, output end_pos,
                    input ready);
    modport sink (input valid, input chrom_id, input start_pos, input end_pos,
                  output ready);
endinterface

>>> hdl/fib_out_if.sv
interface fib_out_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                             valid;
    logic                             ready;
    logic [fib_pkg::CHROM_WIDTH-1:0]   bin_chrom;
    logic [COORD_WIDTH-1:0]           bin_start;
    logic [COORD_WIDTH-1:0]           bin_end;
    logic [fib_pkg::BIN_NUM_WIDTH-1:0] bin_number;
    logic                             last_bin;
    logic                             truncated;

    modport source (output valid, output bin_chrom, output bin_start, output bin_end,
                    output bin_number, output last_bin, output truncated, input ready);
    modport sink (input valid, input bin_chrom, input bin_start, input bin_end,
                  input bin_number, input last_bin, input truncated, output ready);
endinterface

>>> hdl/fixed_interval_binner.sv
// Cuts each interval [start_pos, end_pos) into bins of the configured size, clipped to the
// interval, one bin per output transaction, in ascending order, at most MAX_BINS per
// interval; truncated marks every bin of a run that hit the limit, last_bin its final bin.
// An empty interval yields nothing and the block is ready again on the next cycle. In
// relative mode an accepted interval goes through setup to the emission of its bins; in
// absolute mode the grid origin comes first from a bit-serial remainder of start_pos by
// the bin size, one dividend bit per cycle, before setup and emission. Output stalls
// hold up emission. A bin size of 0 acts as 1. Write configuration only while no
// interval is in progress.
module fixed_interval_binner #(
    parameter int MAX_BINS    = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fib_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [fib_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    fib_in_if.sink                              interval,
    fib_out_if.source                           bin_stream
);

    localparam int SW  = fib_pkg::SIZE_WIDTH;
    localparam int XW  = (COORD_WIDTH > SW ? COORD_WIDTH : SW) + 1;
    localparam int LW  = XW + 7;
    localparam int DCW = $clog2(COORD_WIDTH);
    localparam int NW  = fib_pkg::BIN_NUM_WIDTH;

    fib_pkg::state_t state_reg, state_next;

    logic [SW-1:0]                     bin_width_reg;
    logic                              relative_mode_reg;

    logic [fib_pkg::CHROM_WIDTH-1:0]   chrom_reg, chrom_next;
    logic [COORD_WIDTH-1:0]            start_reg, start_next;
    logic [COORD_WIDTH-1:0]            end_reg, end_next;
    logic [SW-1:0]                     size_reg, size_next;
    logic [LW-1:0]                     span_reg, span_next;
    logic [COORD_WIDTH-1:0]            dvd_reg, dvd_next;
    logic [SW-1:0]                     rem_reg, rem_next;
    logic [DCW-1:0]                    div_cnt_reg, div_cnt_next;
    logic [XW-1:0]                     coord_reg, coord_next;
    logic [NW-1:0]                     count_reg, count_next;
    logic                              trunc_reg, trunc_next;

    logic                              out_valid_reg, out_valid_next;
    logic [fib_pkg::CHROM_WIDTH-1:0]   out_chrom_reg, out_chrom_next;
    logic [COORD_WIDTH-1:0]            out_start_reg, out_start_next;
    logic [COORD_WIDTH-1:0]            out_end_reg, out_end_next;
    logic [NW-1:0]                     out_number_reg, out_number_next;
    logic                              out_last_reg, out_last_next;
    logic                              out_trunc_reg, out_trunc_next;

    logic [SW-1:0]  size_eff;
    logic           accept;
    logic           empty;
    logic           in_ready;
    logic           emit_load;
    logic           div_done;
    logic [SW:0]    trial;
    logic [SW:0]    rem_step;
    logic [XW-1:0]  coord_step;
    logic           step_lt_end;
    logic           bin_last;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg     <= SW'(1);
            relative_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fib_pkg::CFG_BIN_WIDTH:     bin_width_reg     <= cfg_data[SW-1:0];
                fib_pkg::CFG_RELATIVE_MODE: relative_mode_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign size_eff = (bin_width_reg == '0) ? SW'(1) : bin_width_reg;
    assign accept   = interval.valid && in_ready;
    assign empty    = interval.end_pos <= interval.start_pos;

    assign trial    = {rem_reg, dvd_reg[COORD_WIDTH-1]};
    assign rem_step = (trial >= {1'b0, size_reg}) ? trial - {1'b0, size_reg} : trial;
    assign div_done = div_cnt_reg == DCW'(COORD_WIDTH - 1);

    assign coord_step  = coord_reg + XW'(size_reg);
    assign step_lt_end = coord_step < XW'(end_reg);
    assign bin_last    = !step_lt_end || (count_reg == NW'(MAX_BINS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fib_pkg::ST_IDLE:
            begin
                if (accept && !empty)
                begin
                    state_next = relative_mode_reg ? fib_pkg::ST_SETUP : fib_pkg::ST_DIVIDE;
                end
            end
            fib_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = fib_pkg::ST_SETUP;
                end
            end
            fib_pkg::ST_SETUP:
            begin
                state_next = fib_pkg::ST_EMIT;
            end
            fib_pkg::ST_EMIT:
            begin
                if (emit_load && bin_last)
                begin
                    state_next = fib_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fib_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready  = 1'b0;
        emit_load = 1'b0;
        case (state_reg)
            fib_pkg::ST_IDLE:   in_ready  = 1'b1;
            fib_pkg::ST_EMIT:   emit_load = !out_valid_reg || bin_stream.ready;
            default:            ;
        endcase
    end

    // datapath
    always_comb
    begin
        chrom_next      = chrom_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        size_next       = size_reg;
        span_next       = span_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        coord_next      = coord_reg;
        count_next      = count_reg;
        trunc_next      = trunc_reg;
        out_chrom_next  = out_chrom_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        out_number_next = out_number_reg;
        out_last_next   = out_last_reg;
        out_trunc_next  = out_trunc_reg;
        out_valid_next  = out_valid_reg && !bin_stream.ready;

        if (accept)
        begin
            chrom_next   = interval.chrom_id;
            start_next   = interval.start_pos;
            end_next     = interval.end_pos;
            size_next    = size_eff;
            span_next    = LW'(size_eff) * LW'(MAX_BINS);
            dvd_next     = interval.start_pos;
            rem_next     = '0;
            div_cnt_next = '0;
            coord_next   = XW'(interval.start_pos);
        end

        if (state_reg == fib_pkg::ST_DIVIDE)
        begin
            rem_next     = rem_step[SW-1:0];
            dvd_next     = {dvd_reg[COORD_WIDTH-2:0], 1'b0};
            div_cnt_next = div_cnt_reg + DCW'(1);
            if (div_done)
            begin
                coord_next = XW'(start_reg) - XW'(rem_step);
            end
        end

        if (state_reg == fib_pkg::ST_SETUP)
        begin
            trunc_next = (LW'(coord_reg) + span_reg) < LW'(end_reg);
            count_next = '0;
        end

        if (emit_load)
        begin
            out_valid_next  = 1'b1;
            out_chrom_next  = chrom_reg;
            out_start_next  = (count_reg == '0) ? start_reg : coord_reg[COORD_WIDTH-1:0];
            out_end_next    = step_lt_end ? coord_step[COORD_WIDTH-1:0] : end_reg;
            out_number_next = count_reg;
            out_last_next   = bin_last;
            out_trunc_next  = trunc_reg;
            coord_next      = coord_step;
            count_next      = count_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fib_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chrom_reg      <= chrom_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        size_reg       <= size_next;
        span_reg       <= span_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        coord_reg      <= coord_next;
        trunc_reg      <= trunc_next;
        out_chrom_reg  <= out_chrom_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_number_reg <= out_number_next;
        out_last_reg   <= out_last_next;
        out_trunc_reg  <= out_trunc_next;
    end

    assign interval.ready        = in_ready;
    assign bin_stream.valid      = out_valid_reg;
    assign bin_stream.bin_chrom  = out_chrom_reg;
    assign bin_stream.bin_start  = out_start_reg;
    assign bin_stream.bin_end    = out_end_reg;
    assign bin_stream.bin_number = out_number_reg;
    assign bin_stream.last_bin   = out_last_reg;
    assign bin_stream.truncated  = out_trunc_reg;

endmodule
